// ----- design/cic_pkg.sv -----
// Shared types, variant codes and seed table for the cartridge image checksum core.
package cic_pkg;

  typedef enum logic [1:0] {
    VAR_6102 = 2'd0,
    VAR_6103 = 2'd1,
    VAR_6105 = 2'd2,
    VAR_6106 = 2'd3
  } variant_t;

  localparam logic [31:0] SEED_6102 = 32'hF8CA4DDC;
  localparam logic [31:0] SEED_6103 = 32'hA3886759;
  localparam logic [31:0] SEED_6105 = 32'hDF26F436;
  localparam logic [31:0] SEED_6106 = 32'h1FEA617A;

  typedef struct packed {
    logic [31:0] data_word;
    logic [31:0] side_word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] checksum_first;
    logic [31:0] checksum_second;
  } out_item_t;

  typedef struct packed {
    logic [31:0] variant_sum;
    logic [31:0] compare_xor;
    logic [31:0] plain_xor;
    logic [31:0] carry_count;
    logic [31:0] rotate_sum;
    logic [31:0] word_sum;
  } acc_t;

  // Final accumulator values of one area, with the variant that formed them
  typedef struct packed {
    acc_t     acc;
    variant_t variant;
  } fin_t;

  function automatic logic [31:0] seed_of(variant_t v);
    logic [31:0] s;
    case (v)
      VAR_6102: s = SEED_6102;
      VAR_6103: s = SEED_6103;
      VAR_6105: s = SEED_6105;
      VAR_6106: s = SEED_6106;
      default:  s = SEED_6102;
    endcase
    return s;
  endfunction

  function automatic acc_t seed_acc(variant_t v);
    logic [31:0] s;
    acc_t a;
    s = seed_of(v);
    a.variant_sum = s;
    a.compare_xor = s;
    a.plain_xor   = s;
    a.carry_count = s;
    a.rotate_sum  = s;
    a.word_sum    = s;
    return a;
  endfunction

endpackage

// ----- design/cic_accum.sv -----
// Variant register and the six running accumulators, updated once per accepted word.
module cic_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_data,
  input  logic              word_take,
  input  cic_pkg::in_item_t word_in,
  output cic_pkg::fin_t     fin
);
  import cic_pkg::*;

  variant_t    variant;
  acc_t        acc;
  acc_t        upd;
  logic [32:0] word_add;
  logic [63:0] rot_wide;
  logic [31:0] rot;

  always_comb begin
    word_add = {1'b0, acc.word_sum} + {1'b0, word_in.data_word};
    rot_wide = {word_in.data_word, word_in.data_word} << word_in.data_word[4:0];
    rot      = rot_wide[63:32];

    upd.carry_count = acc.carry_count + {31'd0, word_add[32]};
    upd.word_sum    = word_add[31:0];
    upd.plain_xor   = acc.plain_xor ^ word_in.data_word;
    upd.rotate_sum  = acc.rotate_sum + rot;
    // compare uses the old value; the other arm takes the new word sum
    if (acc.compare_xor > word_in.data_word) begin
      upd.compare_xor = acc.compare_xor ^ rot;
    end else begin
      upd.compare_xor = acc.compare_xor ^ upd.word_sum ^ word_in.data_word;
    end
    if (variant == VAR_6105) begin
      upd.variant_sum = acc.variant_sum + (word_in.side_word ^ word_in.data_word);
    end else begin
      upd.variant_sum = acc.variant_sum + (upd.rotate_sum ^ word_in.data_word);
    end
  end

  assign fin.acc     = upd;
  assign fin.variant = variant;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= VAR_6102;
      acc     <= seed_acc(VAR_6102);
    end else if (cfg_write) begin
      variant <= variant_t'(cfg_data);
      acc     <= seed_acc(variant_t'(cfg_data));
    end else if (word_take) begin
      // reload the seed once the area is closed
      if (word_in.last) begin
        acc <= seed_acc(variant);
      end else begin
        acc <= upd;
      end
    end
  end

endmodule

// ----- design/cic_combine.sv -----
// Three-stage combine pipeline: capture, multiply or xor, then final add or xor.
module cic_combine (
  input  logic               clk,
  input  logic               rst,
  input  logic               fin_valid,
  output logic               fin_ready,
  input  cic_pkg::fin_t      fin,
  output logic               out_valid,
  input  logic               out_ready,
  output cic_pkg::out_item_t out_item
);
  import cic_pkg::*;

  logic        cap_valid;
  fin_t        cap;
  logic        mix_valid;
  variant_t    mix_variant;
  logic [31:0] mix_first_a;
  logic [31:0] mix_first_b;
  logic [31:0] mix_second_a;
  logic [31:0] mix_second_b;
  logic        adv_out;
  logic        adv_mix;
  logic        comb_add;
  out_item_t   out_next;

  assign adv_out   = mix_valid && (!out_valid || out_ready);
  assign adv_mix   = cap_valid && (!mix_valid || adv_out);
  assign fin_ready = !cap_valid || adv_mix;

  assign comb_add = (mix_variant == VAR_6103) || (mix_variant == VAR_6106);

  always_comb begin
    if (comb_add) begin
      out_next.checksum_first  = mix_first_a + mix_first_b;
      out_next.checksum_second = mix_second_a + mix_second_b;
    end else begin
      out_next.checksum_first  = mix_first_a ^ mix_first_b;
      out_next.checksum_second = mix_second_a ^ mix_second_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
      mix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_valid && fin_ready) begin
        cap_valid <= 1'b1;
      end else if (adv_mix) begin
        cap_valid <= 1'b0;
      end
      if (adv_mix) begin
        mix_valid <= 1'b1;
      end else if (adv_out) begin
        mix_valid <= 1'b0;
      end
      if (adv_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      cap <= fin;
    end
    if (adv_mix) begin
      mix_variant  <= cap.variant;
      mix_first_b  <= cap.acc.plain_xor;
      mix_second_b <= cap.acc.variant_sum;
      if (cap.variant == VAR_6106) begin
        mix_first_a  <= cap.acc.word_sum * cap.acc.carry_count;
        mix_second_a <= cap.acc.rotate_sum * cap.acc.compare_xor;
      end else begin
        mix_first_a  <= cap.acc.word_sum ^ cap.acc.carry_count;
        mix_second_a <= cap.acc.rotate_sum ^ cap.acc.compare_xor;
      end
    end
    if (adv_out) begin
      out_item <= out_next;
    end
  end

endmodule

// ----- design/cartridge_image_checksum_core.sv -----
// Top level of the cartridge image checksum core.
//
//   channel  signals                         direction  carries
//   in       in_valid / in_ready / in_item   in         image word, side word, last flag
//   out      out_valid / out_ready / out_item out       two 32-bit checksums
//   cfg      cfg_valid / cfg_ready / cfg_data in        variant code (always ready)
//
// One word is taken every cycle unless in_ready is low; accumulators update on acceptance.
// The word marked last hands its final sums to the combine pipeline, and the checksums
// appear after the capture, multiply or xor, and add or xor registers.
// The input stalls only when all three combine stages hold unclaimed results.
// Synchronous reset loads the 6102 seed; a cfg word loads the new variant's seed.
module cartridge_image_checksum_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cic_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cic_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import cic_pkg::*;

  fin_t       fin;
  logic       fin_ready;
  logic       word_take;
  logic       fin_take;
  logic [1:0] pending;

  assign cfg_ready = 1'b1;
  assign in_ready  = fin_ready;
  assign word_take = in_valid && in_ready;
  assign fin_take  = word_take && in_item.last;

  cic_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .word_take (word_take),
    .word_in   (in_item),
    .fin       (fin)
  );

  cic_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_take),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // count closed areas whose checksums are not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      case ({fin_take, out_valid && out_ready})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_out_has_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("checksum word shown with no closed area behind it");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (pending == 2'd3 && out_valid && !out_ready))
    else $error("input stalled while combine pipeline has room");

  a_last_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (fin_take && pending == 2'd0 && !out_valid) |=> ##1 ##1 out_valid)
    else $error("closed area did not reach the output in three cycles");

endmodule
